// ===== rtl/dlmt_pkg.sv =====
`default_nettype none

package dlmt_pkg;

  // input commands
  localparam logic [1:0] CMD_LOAD_TRANS = 2'd0;
  localparam logic [1:0] CMD_LOAD_FLAGS = 2'd1;
  localparam logic [1:0] CMD_DATA       = 2'd2;
  localparam logic [1:0] CMD_END        = 2'd3;

  // result kinds
  localparam logic [1:0] EV_TOKEN    = 2'd0;
  localparam logic [1:0] EV_CLEAN    = 2'd1;
  localparam logic [1:0] EV_UNRECOG  = 2'd2;
  localparam logic [1:0] EV_TOO_LONG = 2'd3;

  localparam logic [5:0] LIMIT_RESET = 6'd32;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [5:0]  token_rule;
    logic [31:0] token_offset;
    logic [5:0]  token_length;
    logic        last;
  } res_t;

  // table write request, raw field widths
  typedef struct packed {
    logic       trans_we;
    logic       flags_we;
    logic [7:0] symbol;
    logic [5:0] state;
    logic [5:0] next;
    logic       valid;
    logic [1:0] flags;
  } tbl_wr_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [5:0] rule,
                                  input logic [31:0] off, input logic [5:0] len);
    res_t r;
    r.event_kind   = kind;
    r.token_rule   = rule;
    r.token_offset = off;
    r.token_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dlmt_in_if.sv =====
`default_nettype none

interface dlmt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_value;
  logic [5:0] table_state;
  logic [5:0] table_next;
  logic       table_valid;
  logic       accept_flag;
  logic       final_flag;

  modport source (output valid, command, byte_value, table_state, table_next,
                  table_valid, accept_flag, final_flag, input ready);
  modport sink (input valid, command, byte_value, table_state, table_next,
                table_valid, accept_flag, final_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/dlmt_out_if.sv =====
`default_nettype none

interface dlmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [5:0]  token_rule;
  logic [31:0] token_offset;
  logic [5:0]  token_length;
  logic        last;

  modport source (output valid, event_kind, token_rule, token_offset, token_length, last,
                  input ready);
  modport sink (input valid, event_kind, token_rule, token_offset, token_length, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/dlmt_tables.sv =====
`default_nettype none

module dlmt_tables #(
  parameter int NUM_STATES = 64
) (
  input  wire                              clk,
  input  wire dlmt_pkg::tbl_wr_t           wr,
  input  wire                              tr_re,
  input  wire [$clog2(NUM_STATES)-1:0]     tr_state,
  input  wire [7:0]                        tr_sym,
  output logic [$clog2(NUM_STATES):0]      tr_q,
  input  wire                              fl_re,
  input  wire [$clog2(NUM_STATES)-1:0]     fl_state,
  output logic [1:0]                       fl_q
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int DEPTH = (2 ** SW) * 256;

  logic [SW:0] tmem [DEPTH];
  logic [1:0]  fmem [2 ** SW];

  logic          st_ok;
  logic          nx_ok;
  logic [SW:0]   tr_wdata;

  assign st_ok    = {3'b000, wr.state} < 9'(NUM_STATES);
  assign nx_ok    = {3'b000, wr.next} < 9'(NUM_STATES);
  assign tr_wdata = (wr.valid && nx_ok) ? {1'b1, SW'(wr.next)} : '0;

  always_ff @(posedge clk) begin
    if (wr.trans_we && st_ok) begin
      tmem[{SW'(wr.state), wr.symbol}] <= tr_wdata;
    end
    if (tr_re) begin
      tr_q <= tmem[{tr_state, tr_sym}];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.flags_we && st_ok) begin
      fmem[SW'(wr.state)] <= wr.flags;
    end
    if (fl_re) begin
      fl_q <= fmem[fl_state];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfa_longest_match_tokenizer.sv =====
`default_nettype none

// Longest-match DFA tokenizer. Load words fill the transition memory (state x byte)
// and the per-state accept/final flags; data words then walk the DFA one byte at a
// time while the current lexeme is kept in a small ring buffer. Entering an
// accepting final state emits a token at once; a dead transition emits the last
// accepted token and replays the surplus bytes from the ring; an end word drains
// what is pending and closes with a clean-end word unless an error ends it. Every
// byte walks a chain of dependent synchronous reads: ring buffer (replay
// only), transition memory, flag memory, then the state update. An item that
// produced results passes a flush step to mark its last result; loads are
// written as they are accepted. Results leave through an output register, so
// the next word is accepted while the final result waits.
module dfa_longest_match_tokenizer #(
  parameter int NUM_STATES = 64,
  parameter int LEXEME_MAX = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire [5:0]        cfg_data,
  dlmt_in_if.sink          items,
  dlmt_out_if.source       results
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int LW = $clog2(LEXEME_MAX + 1);
  localparam int RW = $clog2(LEXEME_MAX);
  localparam logic [LW:0] CAPACITY = (LW + 1)'(LEXEME_MAX);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_TRANS     = 3'd1;
  localparam logic [2:0] ST_FLAGS     = 3'd2;
  localparam logic [2:0] ST_FETCH     = 3'd3;
  localparam logic [2:0] ST_RING      = 3'd4;
  localparam logic [2:0] ST_EOI       = 3'd5;
  localparam logic [2:0] ST_EOI_CLEAN = 3'd6;
  localparam logic [2:0] ST_FLUSH     = 3'd7;

  logic [2:0]    st;
  logic [SW-1:0] cur;
  logic [SW-1:0] acc_state;
  logic          acc_valid;
  logic [LW-1:0] acc_len;
  logic [LW-1:0] lex_len;
  logic [31:0]   lex_start;
  logic [31:0]   stream_off;
  logic [RW-1:0] base;        // ring index of the lexeme's first byte
  logic [LW-1:0] qn;          // bytes waiting behind the lexeme in the ring
  logic          eoi;
  logic [5:0]    limit;

  logic [7:0]    ring [2 ** RW];
  logic [7:0]    ring_q;

  logic              held_v;  // newest result, held until we know whether it is last
  dlmt_pkg::res_t    held;
  logic              out_valid;
  dlmt_pkg::res_t    out_res;
  dlmt_pkg::res_t    out_next;

  // table access
  dlmt_pkg::tbl_wr_t tbl_wr;
  logic              tr_re;
  logic [7:0]        tr_sym;
  logic [SW:0]       tr_q;
  logic              fl_re;
  logic [1:0]        fl_q;

  logic              accept;
  logic [RW-1:0]     head;
  logic [LW-1:0]     nl;
  logic [LW-1:0]     lim;
  logic              hit_limit;
  logic [31:0]       so1;
  logic [31:0]       roll_start;
  logic              tr_valid;
  logic [SW-1:0]     tr_next;
  logic              f_acc;
  logic              f_fin;
  logic [LW-1:0]     qn_dec;
  logic              out_free;
  logic              go;
  logic              emit_v;
  dlmt_pkg::res_t    emit_r;
  logic              out_load;

  assign items.ready = (st == ST_IDLE);
  assign accept      = items.valid && items.ready;

  assign head       = base + RW'(lex_len);
  assign nl         = lex_len + 1'b1;
  assign lim        = ({2'b00, limit} > 8'(LEXEME_MAX)) ? LW'(LEXEME_MAX) : LW'(limit);
  assign hit_limit  = (nl >= lim);
  assign so1        = stream_off + 32'd1;
  assign roll_start = lex_start + 32'(acc_len);
  assign tr_valid   = tr_q[SW];
  assign tr_next    = tr_q[SW-1:0];
  assign f_acc      = fl_q[0];
  assign f_fin      = fl_q[1];
  assign qn_dec     = qn - 1'b1;
  assign out_free   = !out_valid || results.ready;
  assign go         = !held_v || out_free;

  // load decode
  always_comb begin
    tbl_wr.trans_we = accept && (items.command == dlmt_pkg::CMD_LOAD_TRANS);
    tbl_wr.flags_we = accept && (items.command == dlmt_pkg::CMD_LOAD_FLAGS);
    tbl_wr.symbol   = items.byte_value;
    tbl_wr.state    = items.table_state;
    tbl_wr.next     = items.table_next;
    tbl_wr.valid    = items.table_valid;
    tbl_wr.flags    = {items.final_flag, items.accept_flag};
  end

  // transition read: first byte straight from the input word, replayed bytes from the ring
  assign tr_re  = (accept && (items.command == dlmt_pkg::CMD_DATA)) || (st == ST_RING);
  assign tr_sym = (st == ST_IDLE) ? items.byte_value : ring_q;
  assign fl_re  = (st == ST_TRANS);

  dlmt_tables #(
    .NUM_STATES (NUM_STATES)
  ) u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .tr_re    (tr_re),
    .tr_state (cur),
    .tr_sym   (tr_sym),
    .tr_q     (tr_q),
    .fl_re    (fl_re),
    .fl_state (tr_next),
    .fl_q     (fl_q)
  );

  // lexeme ring: new byte lands right behind the lexeme, replay reads at the same spot
  always_ff @(posedge clk) begin
    if (accept && (items.command == dlmt_pkg::CMD_DATA)) begin
      ring[head] <= items.byte_value;
    end
    if (st == ST_FETCH) begin
      ring_q <= ring[head];
    end
  end

  // result of the current step
  always_comb begin
    emit_v = 1'b0;
    emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_TOKEN, 6'd0, 32'd0, 6'd0);
    unique case (st)
      ST_FLAGS: begin
        if (hit_limit) begin
          emit_v = 1'b1;
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_TOO_LONG, 6'd0, lex_start, 6'd0);
        end else if (tr_valid) begin
          if (f_acc && f_fin) begin
            emit_v = 1'b1;
            emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_TOKEN, 6'(tr_next), lex_start, 6'(nl));
          end
        end else if (acc_valid) begin
          emit_v = 1'b1;
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_TOKEN, 6'(acc_state), lex_start,
                                    6'(acc_len));
        end else begin
          emit_v = 1'b1;
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_UNRECOG, 6'd0, lex_start, 6'd0);
        end
      end
      ST_EOI: begin
        emit_v = 1'b1;
        if (lex_len == '0) begin
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_CLEAN, 6'd0, stream_off, 6'd0);
        end else if (!acc_valid) begin
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_UNRECOG, 6'd0, lex_start, 6'd0);
        end else begin
          // full match or rollback: either way the token spans the accepted prefix
          emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_TOKEN, 6'(acc_state), lex_start,
                                    6'(acc_len));
        end
      end
      ST_EOI_CLEAN: begin
        emit_v = 1'b1;
        emit_r = dlmt_pkg::mk_res(dlmt_pkg::EV_CLEAN, 6'd0, stream_off, 6'd0);
      end
      default: begin
      end
    endcase
  end

  // a held result moves out either when a newer one replaces it or at the item's end
  assign out_load = (emit_v && go && held_v) || ((st == ST_FLUSH) && held_v && out_free);

  always_comb begin
    out_next      = held;
    out_next.last = (st == ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= out_next;
    end
    if (emit_v && go) begin
      held <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      cur        <= '0;
      acc_state  <= '0;
      acc_valid  <= 1'b0;
      acc_len    <= '0;
      lex_len    <= '0;
      lex_start  <= '0;
      stream_off <= '0;
      base       <= '0;
      qn         <= '0;
      eoi        <= 1'b0;
      limit      <= dlmt_pkg::LIMIT_RESET;
      held_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      if (emit_v && go) begin
        held_v <= 1'b1;
      end else if ((st == ST_FLUSH) && out_load) begin
        held_v <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          if (accept) begin
            case (items.command)
              dlmt_pkg::CMD_DATA: begin
                qn  <= LW'(1);
                eoi <= 1'b0;
                st  <= ST_TRANS;
              end
              dlmt_pkg::CMD_END: begin
                eoi <= 1'b1;
                st  <= ST_EOI;
              end
              default: begin
              end
            endcase
          end
        end

        ST_FETCH: st <= ST_RING;
        ST_RING:  st <= ST_TRANS;
        ST_TRANS: st <= ST_FLAGS;

        ST_FLAGS: begin
          if (go) begin
            if (hit_limit || (!tr_valid && !acc_valid)) begin
              // error: restart and drop whatever is left to replay
              stream_off <= so1;
              cur        <= '0;
              acc_state  <= '0;
              acc_valid  <= 1'b0;
              acc_len    <= '0;
              lex_len    <= '0;
              lex_start  <= so1;
              qn         <= '0;
              st         <= ST_FLUSH;
            end else if (tr_valid) begin
              stream_off <= so1;
              if (f_acc && f_fin) begin
                cur       <= '0;
                acc_state <= '0;
                acc_valid <= 1'b0;
                acc_len   <= '0;
                lex_len   <= '0;
                lex_start <= so1;
                base      <= base + RW'(nl);
              end else begin
                cur     <= tr_next;
                lex_len <= nl;
                if (f_acc) begin
                  acc_state <= tr_next;
                  acc_len   <= nl;
                  acc_valid <= 1'b1;
                end
              end
              qn <= qn_dec;
              if (qn_dec != '0) begin
                st <= ST_FETCH;
              end else if (eoi) begin
                st <= ST_EOI;
              end else begin
                st <= (held_v || emit_v) ? ST_FLUSH : ST_IDLE;
              end
            end else begin
              // dead transition: roll back to the accepted prefix, replay the rest
              stream_off <= roll_start;
              lex_start  <= roll_start;
              base       <= base + RW'(acc_len);
              qn         <= qn_dec + (nl - acc_len);
              cur        <= '0;
              acc_state  <= '0;
              acc_valid  <= 1'b0;
              acc_len    <= '0;
              lex_len    <= '0;
              st         <= ST_FETCH;
            end
          end
        end

        ST_EOI: begin
          if (go) begin
            if (lex_len == '0) begin
              st <= ST_FLUSH;
            end else begin
              cur       <= '0;
              acc_state <= '0;
              acc_valid <= 1'b0;
              acc_len   <= '0;
              lex_len   <= '0;
              if (!acc_valid) begin
                lex_start <= stream_off;
                st        <= ST_FLUSH;
              end else if (acc_len >= lex_len) begin
                lex_start <= stream_off;
                base      <= base + RW'(lex_len);
                st        <= ST_EOI_CLEAN;
              end else begin
                stream_off <= roll_start;
                lex_start  <= roll_start;
                base       <= base + RW'(acc_len);
                qn         <= lex_len - acc_len;
                st         <= ST_FETCH;
              end
            end
          end
        end

        ST_EOI_CLEAN: begin
          if (go) begin
            st <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          if (!held_v || out_free) begin
            st <= ST_IDLE;
          end
        end

        default: st <= ST_IDLE;
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.event_kind   = out_res.event_kind;
  assign results.token_rule   = out_res.token_rule;
  assign results.token_offset = out_res.token_offset;
  assign results.token_length = out_res.token_length;
  assign results.last         = out_res.last;

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> !held_v)
    else $error("result still held while idle");

  a_ring_capacity: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, qn} + {1'b0, lex_len}) <= CAPACITY)
    else $error("lexeme plus replay queue exceeds ring");

  a_accept_within_lexeme: assert property (@(posedge clk) disable iff (rst)
    acc_valid |-> (acc_len <= lex_len))
    else $error("accepted length beyond lexeme");

  a_fetch_has_byte: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FETCH) |-> (qn != '0))
    else $error("replay fetch with empty queue");

endmodule

`default_nettype wire
